// File: rtl/ymr_pkg.sv
// Shared types, protocol byte codes and CRC helpers for the YModem receiver.
// No dependencies; every other file of the block imports this package.
package ymr_pkg;

   // Payload of one input beat.
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
   } req_type;

   // Payload of one result beat.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic       last;
   } rsp_type;

   localparam int MAX_RES = 6;
   localparam int RES_CNT_W = $clog2(MAX_RES + 1);

   // All results caused by one input item, loaded into the output buffer at once.
   typedef struct packed {
      logic [RES_CNT_W-1:0]      count;
      rsp_type [MAX_RES-1:0]     item;
   } rsp_batch_type;

   typedef struct packed {
      logic [7:0]  err_limit;
      logic [15:0] nak_timeout_ms;
   } cfg_type;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERR_LIMIT      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAK_TIMEOUT_MS = 1'b1;
   localparam logic [7:0]  ERR_LIMIT_RST      = 8'd5;
   localparam logic [15:0] NAK_TIMEOUT_MS_RST = 16'd1000;

   // Input commands.
   localparam logic [1:0] CMD_BYTE      = 2'd0;
   localparam logic [1:0] CMD_FRAME_END = 2'd1;
   localparam logic [1:0] CMD_TICK      = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_TX      = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_EVENT   = 2'd2;

   // Event codes.
   localparam logic [7:0] EV_FILE_INFO = 8'd0;
   localparam logic [7:0] EV_FILE_DATA = 8'd1;
   localparam logic [7:0] EV_EXIT      = 8'd2;
   localparam logic [7:0] EV_REJECT    = 8'd3;

   // Protocol bytes.
   localparam logic [7:0] B_SOH = 8'h01;
   localparam logic [7:0] B_STX = 8'h02;
   localparam logic [7:0] B_ETX = 8'h03;
   localparam logic [7:0] B_EOT = 8'h04;
   localparam logic [7:0] B_ACK = 8'h06;
   localparam logic [7:0] B_NAK = 8'h15;
   localparam logic [7:0] B_CA  = 8'h18;
   localparam logic [7:0] B_C   = 8'h43;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam int POS_W = 11;
   localparam logic [POS_W-1:0] POS_MAX = 11'd2047;

   // CRC-16 update by one byte, MSB first.
   function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
      end
      return r;
   endfunction

   // Payload length implied by the header byte, zero for other headers.
   function automatic logic [POS_W-1:0] payload_len(input logic [7:0] b0);
      logic [POS_W-1:0] len;
      len = '0;
      if (b0 == B_SOH) begin
         len = 11'd128;
      end else if (b0 == B_STX) begin
         len = 11'd1024;
      end
      return len;
   endfunction

   function automatic rsp_type mk_rsp(input logic [1:0] kind, input logic [7:0] value);
      rsp_type r;
      r.kind  = kind;
      r.value = value;
      r.last  = 1'b0;
      return r;
   endfunction

endpackage

// File: rtl/ymodem_receiver.sv
// Top level of the YModem receiver; depends on ymr_pkg, ymr_engine and ymr_rsp_buf.
// Path: an accepted beat waits in the input register until the result buffer is free; it is
// then decoded, and its results are registered in the result buffer before they are offered.
// Throughput: one input beat per cycle while each item yields at most one result and rsp_ready
// stays high; an item with more results holds the result buffer until the last is taken.
// Reset (synchronous, active high) clears the protocol state; retry limit 5, timeout 1000 ms.
module ymodem_receiver
   import ymr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata
);

   // Input register: one item waits here until the result buffer can take its batch.
   logic          in_valid_ff, in_valid_in;
   req_type       in_item_ff;
   logic          fire;
   logic          buf_free;
   rsp_batch_type batch;
   cfg_type       cfg_ff;

   // The engine fires when an item is held and the buffer is empty or drains its last beat
   // this cycle, so a new beat can be taken in the same cycle the held one is consumed.
   assign fire        = in_valid_ff && buf_free;
   assign req_ready   = !in_valid_ff || fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
   end

   // Configuration registers; the user must write only while the block is idle; not enforced.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.err_limit      <= ERR_LIMIT_RST;
         cfg_ff.nak_timeout_ms <= NAK_TIMEOUT_MS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ERR_LIMIT:      cfg_ff.err_limit      <= csr_wdata[7:0];
            CSR_NAK_TIMEOUT_MS: cfg_ff.nak_timeout_ms <= csr_wdata;
            default:            cfg_ff                <= cfg_ff;
         endcase
      end
   end

   ymr_engine u_engine (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (in_item_ff),
      .cfg   (cfg_ff),
      .batch (batch)
   );

   ymr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .batch     (batch),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/ymr_engine.sv
// Protocol engine of the YModem receiver: frame tracking, CRC, counters and reply generation.
// Depends on ymr_pkg; one item is processed per firing cycle into a batch of results.
module ymr_engine
   import ymr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          fire,
   input  req_type       item,
   input  cfg_type       cfg,
   output rsp_batch_type batch
);

   typedef enum logic [1:0] {
      PH_HEADER = 2'b01,
      PH_DATA   = 2'b10
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [7:0]         exp_seq_ff, exp_seq_in;
   logic [7:0]         nak_err_ff, nak_err_in;
   logic [7:0]         retry_ff, retry_in;
   logic               eot_seen_ff, eot_seen_in;
   logic [15:0]        idle_ff, idle_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [15:0]        crc_ff, crc_in;
   logic [31:0]        head_ff, head_in;
   logic [15:0]        tail_ff, tail_in;

   logic [RES_CNT_W-1:0] n;
   logic [7:0]           b0, b1, b2, b3;
   logic [POS_W-1:0]     len;
   logic                 good;
   logic [31:0]          head_b;
   logic [15:0]          tail_b, crc_b, idle_sat;
   logic [POS_W-1:0]     len_b;
   logic                 do_cancel, do_exit;

   // Fields of the frame that just ended.
   assign b0   = head_ff[7:0];
   assign b1   = head_ff[15:8];
   assign b2   = head_ff[23:16];
   assign b3   = head_ff[31:24];
   assign len  = payload_len(b0);
   assign good = (len != '0) && (b1 == exp_seq_ff) && (b2 == ~exp_seq_ff)
                 && (pos_ff == len + 11'd5) && (crc_ff == tail_ff);

   always_comb begin
      phase_in    = phase_ff;
      exp_seq_in  = exp_seq_ff;
      nak_err_in  = nak_err_ff;
      retry_in    = retry_ff;
      eot_seen_in = eot_seen_ff;
      idle_in     = idle_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      batch       = '0;
      n           = '0;
      head_b      = (pos_ff == '0) ? 32'd0 : head_ff;
      tail_b      = (pos_ff == '0) ? 16'd0 : tail_ff;
      crc_b       = (pos_ff == '0) ? 16'd0 : crc_ff;
      len_b       = '0;
      idle_sat    = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      do_cancel   = 1'b0;
      do_exit     = 1'b0;

      if (fire) begin
         unique case (item.cmd)
            CMD_BYTE: begin
               if (pos_ff < 11'd4) begin
                  unique case (pos_ff[1:0])
                     2'd0: head_b[7:0]   = item.rx_byte;
                     2'd1: head_b[15:8]  = item.rx_byte;
                     2'd2: head_b[23:16] = item.rx_byte;
                     2'd3: head_b[31:24] = item.rx_byte;
                     default: head_b = head_b;
                  endcase
               end
               len_b   = payload_len(head_b[7:0]);
               head_in = head_b;
               tail_in = tail_b;
               crc_in  = crc_b;
               if (len_b != '0 && pos_ff >= 11'd3 && pos_ff < len_b + 11'd3) begin
                  batch.item[n] = mk_rsp(KIND_PAYLOAD, item.rx_byte);
                  n = n + 1'b1;
                  crc_in = crc16_byte(crc_b, item.rx_byte);
               end else if (len_b != '0 && pos_ff >= len_b + 11'd3) begin
                  tail_in = {tail_b[7:0], item.rx_byte};
               end
               if (pos_ff != POS_MAX) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            CMD_FRAME_END: begin
               if (pos_ff != '0) begin
                  if (b0 == B_EOT) begin
                     if (!eot_seen_ff) begin
                        eot_seen_in = 1'b1;
                        batch.item[n] = mk_rsp(KIND_TX, B_NAK);
                        n = n + 1'b1;
                     end else begin
                        eot_seen_in = 1'b0;
                        batch.item[n] = mk_rsp(KIND_TX, B_ACK);
                        n = n + 1'b1;
                        batch.item[n] = mk_rsp(KIND_TX, B_C);
                        n = n + 1'b1;
                        phase_in   = PH_HEADER;
                        exp_seq_in = '0;
                        nak_err_in = '0;
                        retry_in   = '0;
                     end
                  end else if (b0 == B_ETX || (b0 == B_CA && b1 == B_CA)) begin
                     do_cancel = 1'b1;
                     do_exit   = 1'b1;
                  end else if (phase_ff == PH_HEADER) begin
                     if (good && b3 != 8'd0) begin
                        batch.item[n] = mk_rsp(KIND_EVENT, EV_FILE_INFO);
                        n = n + 1'b1;
                        exp_seq_in = exp_seq_ff + 8'd1;
                        batch.item[n] = mk_rsp(KIND_TX, B_ACK);
                        n = n + 1'b1;
                        nak_err_in = '0;
                        batch.item[n] = mk_rsp(KIND_TX, B_C);
                        n = n + 1'b1;
                        phase_in = PH_DATA;
                     end else if (good) begin
                        // A header with an empty file name ends the session.
                        batch.item[n] = mk_rsp(KIND_EVENT, EV_REJECT);
                        n = n + 1'b1;
                        do_exit = 1'b1;
                     end else begin
                        if (len != '0) begin
                           batch.item[n] = mk_rsp(KIND_EVENT, EV_REJECT);
                           n = n + 1'b1;
                        end
                        batch.item[n] = mk_rsp(KIND_TX, B_C);
                        n = n + 1'b1;
                        if (retry_ff >= cfg.err_limit) begin
                           do_cancel = 1'b1;
                           do_exit   = 1'b1;
                        end else if (retry_ff != 8'hFF) begin
                           retry_in = retry_ff + 8'd1;
                        end
                     end
                  end else begin
                     if (good) begin
                        batch.item[n] = mk_rsp(KIND_EVENT, EV_FILE_DATA);
                        n = n + 1'b1;
                        exp_seq_in = exp_seq_ff + 8'd1;
                        retry_in   = '0;
                        batch.item[n] = mk_rsp(KIND_TX, B_ACK);
                        n = n + 1'b1;
                        nak_err_in = '0;
                     end else begin
                        if (len != '0) begin
                           batch.item[n] = mk_rsp(KIND_EVENT, EV_REJECT);
                           n = n + 1'b1;
                        end
                        retry_in = '0;
                        batch.item[n] = mk_rsp(KIND_TX, B_NAK);
                        n = n + 1'b1;
                        nak_err_in = (nak_err_ff == 8'hFF) ? nak_err_ff : nak_err_ff + 8'd1;
                        if (nak_err_in > cfg.err_limit) begin
                           do_cancel = 1'b1;
                           do_exit   = 1'b1;
                        end
                     end
                  end
                  pos_in  = '0;
                  idle_in = '0;
               end
            end
            CMD_TICK: begin
               idle_in = idle_sat;
               if (idle_sat >= cfg.nak_timeout_ms) begin
                  if (phase_ff == PH_HEADER) begin
                     batch.item[n] = mk_rsp(KIND_TX, B_C);
                     n = n + 1'b1;
                     phase_in   = PH_HEADER;
                     exp_seq_in = '0;
                     nak_err_in = '0;
                     retry_in   = '0;
                     idle_in    = '0;
                  end else begin
                     do_exit = 1'b1;
                  end
               end
            end
            default: begin
               n = '0;
            end
         endcase

         // Cancel sends CA CA; every exit sends ACK and the exit event, then restarts.
         if (do_cancel) begin
            batch.item[n] = mk_rsp(KIND_TX, B_CA);
            n = n + 1'b1;
            batch.item[n] = mk_rsp(KIND_TX, B_CA);
            n = n + 1'b1;
         end
         if (do_exit) begin
            batch.item[n] = mk_rsp(KIND_TX, B_ACK);
            n = n + 1'b1;
            batch.item[n] = mk_rsp(KIND_EVENT, EV_EXIT);
            n = n + 1'b1;
            phase_in   = PH_HEADER;
            exp_seq_in = '0;
            nak_err_in = '0;
            retry_in   = '0;
            idle_in    = '0;
         end
         if (n != '0) begin
            batch.item[n - 1'b1].last = 1'b1;
         end
      end
      batch.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         exp_seq_ff  <= '0;
         nak_err_ff  <= '0;
         retry_ff    <= '0;
         eot_seen_ff <= 1'b0;
         idle_ff     <= '0;
         pos_ff      <= '0;
         crc_ff      <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
      end else begin
         phase_ff    <= phase_in;
         exp_seq_ff  <= exp_seq_in;
         nak_err_ff  <= nak_err_in;
         retry_ff    <= retry_in;
         eot_seen_ff <= eot_seen_in;
         idle_ff     <= idle_in;
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
      end
   end

endmodule

// File: rtl/ymr_rsp_buf.sv
// Result buffer of the YModem receiver: holds one item's batch and drains it beat by beat.
// Depends on ymr_pkg.
module ymr_rsp_buf
   import ymr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsp_batch_type batch,
   output logic          free,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   rsp_type              res_ff [MAX_RES];
   logic [RES_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RES_CNT_W-1:0] idx_ff, idx_in;
   logic                 pop;

   assign rsp_valid = (idx_ff != cnt_ff);
   assign pop       = rsp_valid && rsp_ready;
   assign free      = (idx_ff == cnt_ff) || (pop && (idx_ff + 1'b1 == cnt_ff));
   assign rsp_data  = (idx_ff < RES_CNT_W'(MAX_RES)) ? res_ff[idx_ff] : res_ff[0];

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = batch.count;
         idx_in = '0;
      end else if (pop) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MAX_RES; i++) begin
            res_ff[i] <= batch.item[i];
         end
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RES_CNT_W'(MAX_RES))
      else $error("result count exceeds buffer depth");

   a_idx_le_cnt: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= cnt_ff)
      else $error("read index ran past result count");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("batch loaded over undelivered results");

   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == (idx_ff + 1'b1 == cnt_ff)))
      else $error("last flag not on the final result of an item");

endmodule

// File: verif/ymr_reply_checker.sv
`timescale 1ns / 1ps
// Reply checker for the YModem receiver: watches the request, result and register ports,
// predicts every result beat and compares it with what the block sends. Depends on ymr_pkg.
module ymr_reply_checker
   import ymr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]            csr_wdata,
   output int                     mismatches,
   output int                     replies_waiting,
   output logic [7:0]             next_seq
);

   typedef enum logic [1:0] {
      AWAIT_HEADER = 2'b01,
      IN_DATA      = 2'b10
   } link_phase_type;

   // Register copies.
   logic [7:0]  retry_limit;
   logic [15:0] idle_limit_ms;

   // Protocol state of the receiver.
   link_phase_type link;
   logic [7:0]  expected_seq;
   logic [7:0]  nak_count;
   logic [7:0]  header_retries;
   logic [1:0]  eot_count;
   logic [15:0] idle_ms;
   logic [10:0] frame_bytes;
   logic [15:0] payload_crc;
   logic [31:0] head;
   logic [15:0] tail;

   rsp_type replies_due[$];
   rsp_type beat_replies[$];
   rsp_type want;
   int      fails = 0;

   function automatic logic [15:0] crc_after(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic int block_size(logic [7:0] b0);
      if (b0 == B_SOH) begin
         return 128;
      end else if (b0 == B_STX) begin
         return 1024;
      end
      return 0;
   endfunction

   // At most six results can come from one beat.
   function automatic void emit(logic [1:0] kind, logic [7:0] value);
      rsp_type r;
      r.kind = kind;
      r.value = value;
      r.last = 1'b0;
      if (beat_replies.size() < MAX_RES) begin
         beat_replies.push_back(r);
      end
   endfunction

   function automatic void restart_link();
      link = AWAIT_HEADER;
      expected_seq = '0;
      nak_count = '0;
      header_retries = '0;
      idle_ms = '0;
   endfunction

   function automatic void close_transfer(bit cancel);
      if (cancel) begin
         emit(KIND_TX, B_CA);
         emit(KIND_TX, B_CA);
      end
      emit(KIND_TX, B_ACK);
      emit(KIND_EVENT, EV_EXIT);
      restart_link();
   endfunction

   function automatic void send_ack();
      emit(KIND_TX, B_ACK);
      nak_count = '0;
   endfunction

   function automatic bit send_nak();
      emit(KIND_TX, B_NAK);
      if (nak_count != 8'hFF) begin
         nak_count++;
      end
      return nak_count > retry_limit;
   endfunction

   // The first EOT is refused, the repeat confirms the end of the file.
   function automatic void take_eot();
      if (eot_count == 0) begin
         eot_count = 2'd1;
         emit(KIND_TX, B_NAK);
      end else begin
         eot_count = 2'd0;
         emit(KIND_TX, B_ACK);
         emit(KIND_TX, B_C);
         restart_link();
      end
   endfunction

   function automatic void take_byte(logic [7:0] b);
      int pos;
      int len;
      pos = frame_bytes;
      if (pos == 0) begin
         head = '0;
         tail = '0;
         payload_crc = '0;
      end
      if (pos < 4) begin
         head[8*pos +: 8] = b;
      end
      len = block_size(head[7:0]);
      if (len != 0 && pos >= 3 && pos < 3 + len) begin
         emit(KIND_PAYLOAD, b);
         payload_crc = crc_after(payload_crc, b);
      end else if (len != 0 && pos >= 3 + len) begin
         tail = {tail[7:0], b};
      end
      if (pos < 2047) begin
         frame_bytes = 11'(pos + 1);
      end
   endfunction

   function automatic void close_frame();
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      int         len;
      bit         good;
      b0 = head[7:0];
      b1 = head[15:8];
      b2 = head[23:16];
      b3 = head[31:24];
      len = block_size(b0);
      good = len != 0 && b1 == expected_seq && b2 == ~expected_seq
         && int'(frame_bytes) == len + 5 && payload_crc == tail;
      if (b0 == B_EOT) begin
         take_eot();
      end else if (b0 == B_ETX || (b0 == B_CA && b1 == B_CA)) begin
         close_transfer(1'b1);
      end else if (link == AWAIT_HEADER) begin
         if (good && b3 != 8'h00) begin
            emit(KIND_EVENT, EV_FILE_INFO);
            expected_seq++;
            send_ack();
            emit(KIND_TX, B_C);
            link = IN_DATA;
         end else if (good) begin
            // Header block with an empty file name ends the session.
            emit(KIND_EVENT, EV_REJECT);
            close_transfer(1'b0);
         end else begin
            if (len != 0) begin
               emit(KIND_EVENT, EV_REJECT);
            end
            emit(KIND_TX, B_C);
            if (header_retries >= retry_limit) begin
               close_transfer(1'b1);
            end else if (header_retries != 8'hFF) begin
               header_retries++;
            end
         end
      end else begin
         if (good) begin
            emit(KIND_EVENT, EV_FILE_DATA);
            expected_seq++;
            header_retries = '0;
            send_ack();
         end else begin
            if (len != 0) begin
               emit(KIND_EVENT, EV_REJECT);
            end
            header_retries = '0;
            if (send_nak()) begin
               close_transfer(1'b1);
            end
         end
      end
      frame_bytes = '0;
      idle_ms = '0;
   endfunction

   function automatic void take_tick();
      if (idle_ms != 16'hFFFF) begin
         idle_ms++;
      end
      if (idle_ms >= idle_limit_ms) begin
         if (link == AWAIT_HEADER) begin
            emit(KIND_TX, B_C);
            restart_link();
         end else begin
            close_transfer(1'b0);
         end
      end
   endfunction

   function automatic void advance_receiver(req_type beat);
      beat_replies.delete();
      case (beat.cmd)
         CMD_BYTE: begin
            take_byte(beat.rx_byte);
         end
         CMD_FRAME_END: begin
            if (frame_bytes != 0) begin
               close_frame();
            end
         end
         CMD_TICK: begin
            take_tick();
         end
         default: begin
         end
      endcase
      if (beat_replies.size() > 0) begin
         beat_replies[beat_replies.size() - 1].last = 1'b1;
      end
      foreach (beat_replies[i]) begin
         replies_due.push_back(beat_replies[i]);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         retry_limit = ERR_LIMIT_RST;
         idle_limit_ms = NAK_TIMEOUT_MS_RST;
         restart_link();
         eot_count = '0;
         frame_bytes = '0;
         payload_crc = '0;
         head = '0;
         tail = '0;
         replies_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               fails++;
               $display("%0t: result with none expected: got kind=%0d value=%h last=%b",
                  $time, rsp_data.kind, rsp_data.value, rsp_data.last);
            end else begin
               want = replies_due.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.value !== want.value
                     || rsp_data.last !== want.last) begin
                  fails++;
                  $display("%0t: result mismatch: expected kind=%0d value=%h last=%b,",
                     $time, want.kind, want.value, want.last,
                     " got kind=%0d value=%h last=%b",
                     rsp_data.kind, rsp_data.value, rsp_data.last);
               end
            end
         end
         if (req_valid && req_ready) begin
            advance_receiver(req_data);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ERR_LIMIT: begin
                  retry_limit = csr_wdata[7:0];
               end
               CSR_NAK_TIMEOUT_MS: begin
                  idle_limit_ms = csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
      mismatches <= fails;
      replies_waiting <= replies_due.size();
      next_seq <= expected_seq;
   end

endmodule

// File: verif/tb_ymodem_receiver.sv
`timescale 1ns / 1ps
// Top of the YModem receiver testbench: clock, reset, stimulus, result back-pressure and
// verdict. Depends on ymr_pkg, ymodem_receiver and ymr_reply_checker.
module tb_ymodem_receiver
   import ymr_pkg::*;
();

   // The command code that the block must ignore.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Random items per register setting, counted from the start of each setting.
   localparam int PHASE_ITEMS = 40;
   // Quiet cycles after the last expected result before registers change or the run ends.
   // The first result of a beat is registered before it is offered, so this is ample.
   localparam int SETTLE_CYCLES = 16;
   // The one long stretch in which the result side refuses everything.
   localparam int HOLD_OFF_CYCLES = 400;
   // Cycles without any beat on either channel before the run is declared hung. The longest
   // legal quiet stretch is the hold-off above plus the longest sender gap.
   localparam int STALL_LIMIT = 4000;

   // Ways in which a generated block can be spoiled.
   typedef enum int {
      FLAW_NONE,
      FLAW_SEQ,
      FLAW_CMPL,
      FLAW_CRC,
      FLAW_SHORT,
      FLAW_LONG,
      FLAW_NO_NAME
   } frame_flaw_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]            csr_wdata = '0;

   int                     mismatches;
   int                     replies_waiting;
   logic [7:0]             next_seq;

   int                     items_sent = 0;
   int                     quiet_cycles = 0;
   // When set, the sender offers beats back to back for the current scenario.
   bit                     calm = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ymodem_receiver uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ymr_reply_checker reply_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .replies_waiting (replies_waiting),
      .next_seq        (next_seq)
   );

   // Offers one beat and returns at the clock edge that accepts it. Valid stays high on
   // return so that a following beat without a gap goes out on the very next cycle. Most
   // gaps are short; about one in ten is long enough to drain the block completely.
   task automatic send_item(input logic [1:0] cmd, input logic [7:0] b);
      int gap;
      gap = 0;
      if (!calm) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap = 0;
            6, 7, 8:          gap = $urandom_range(1, 3);
            default:          gap = $urandom_range(8, 30);
         endcase
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{cmd: cmd, rx_byte: b};
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Registers may only change while the block is idle. The first edge lets the checker
   // count the results of the beat that was just accepted; after the last result, a few
   // more cycles cover a beat that produces no result at all.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_waiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers on consecutive cycles. The upper byte of the retry limit
   // write carries noise, which the block has to ignore.
   task automatic configure(input logic [7:0] errs, input logic [15:0] ms);
      csr_we <= 1'b1;
      csr_index <= CSR_ERR_LIMIT;
      csr_wdata <= {8'($urandom), errs};
      @(posedge clock);
      csr_index <= CSR_NAK_TIMEOUT_MS;
      csr_wdata <= ms;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Sends one complete 128-byte YModem block: header, block number, its complement,
   // payload and CRC, then the frame end. Most blocks are well formed so that the receiver
   // actually advances through the header and data phases; the rest carry exactly one flaw.
   task automatic send_block_frame();
      logic [7:0]     hdr;
      logic [7:0]     num;
      logic [7:0]     body;
      logic [15:0]    crc;
      int             len;
      frame_flaw_type flaw;
      // An idle edge with valid low comes first, so that the block number seen from the
      // checker already reflects the beat accepted just before.
      req_valid <= 1'b0;
      @(posedge clock);
      hdr = B_SOH;
      len = int'(payload_len(hdr));
      flaw = FLAW_NONE;
      if ($urandom_range(0, 9) >= 7) begin
         flaw = frame_flaw_type'($urandom_range(int'(FLAW_SEQ), int'(FLAW_NO_NAME)));
      end
      num = next_seq;
      if (flaw == FLAW_SEQ) begin
         // A repeat of the previous block counts as an error like any other.
         num = num - 8'd1;
      end
      send_item(CMD_BYTE, hdr);
      send_item(CMD_BYTE, num);
      send_item(CMD_BYTE, (flaw == FLAW_CMPL) ? num : ~num);
      crc = '0;
      for (int i = 0; i < len; i++) begin
         body = 8'($urandom);
         if (i == 0) begin
            // The first payload byte of a header block starts the file name.
            if (flaw == FLAW_NO_NAME) begin
               body = 8'h00;
            end else if (body == 8'h00) begin
               body = 8'h2E;
            end
         end
         crc = crc16_byte(crc, body);
         send_item(CMD_BYTE, body);
      end
      if (flaw == FLAW_CRC) begin
         crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      end
      send_item(CMD_BYTE, crc[15:8]);
      if (flaw != FLAW_SHORT) begin
         send_item(CMD_BYTE, crc[7:0]);
      end
      if (flaw == FLAW_LONG) begin
         send_item(CMD_BYTE, 8'($urandom));
      end
      send_item(CMD_FRAME_END, 8'($urandom));
   endtask

   // One random scenario. Full blocks dominate the item count; the rest are EOTs, aborts,
   // bursts of millisecond ticks, short garbage frames and beats the block ignores.
   task automatic run_scenario();
      int pick;
      int n;
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         send_block_frame();
      end else if (pick < 47) begin
         // End of file, sometimes with trailing garbage, and often confirmed right away.
         n = $urandom_range(1, 2);
         repeat (n) begin
            send_item(CMD_BYTE, B_EOT);
            if ($urandom_range(0, 3) == 0) begin
               send_item(CMD_BYTE, 8'($urandom));
            end
            send_item(CMD_FRAME_END, 8'($urandom));
         end
      end else if (pick < 52) begin
         if ($urandom_range(0, 1) == 0) begin
            send_item(CMD_BYTE, B_ETX);
         end else begin
            send_item(CMD_BYTE, B_CA);
            send_item(CMD_BYTE, B_CA);
         end
         send_item(CMD_FRAME_END, 8'($urandom));
      end else if (pick < 70) begin
         n = $urandom_range(1, 8);
         repeat (n) send_item(CMD_TICK, 8'($urandom));
      end else if (pick < 90) begin
         // A short frame whose header is often one of the interesting bytes.
         n = $urandom_range(1, 6);
         case ($urandom_range(0, 3))
            0:       send_item(CMD_BYTE, B_SOH);
            1:       send_item(CMD_BYTE, B_STX);
            2:       send_item(CMD_BYTE, B_CA);
            default: send_item(CMD_BYTE, 8'($urandom));
         endcase
         repeat (n - 1) send_item(CMD_BYTE, 8'($urandom));
         send_item(CMD_FRAME_END, 8'($urandom));
      end else if (pick < 95) begin
         send_item(CMD_FRAME_END, 8'($urandom));
      end else begin
         send_item(CMD_UNUSED, 8'($urandom));
      end
   endtask

   // Result side. Ready drops now and then, in short stalls far more often than long ones,
   // with steady stretches in between. Once, after the first few blocks, it stays low for a
   // long time so that the block fills up and stalls its input.
   initial begin : result_sink
      int stall_left;
      int beats_taken;
      bit held_off;
      bit steady;
      stall_left = 0;
      beats_taken = 0;
      held_off = 1'b0;
      steady = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            beats_taken++;
         end
         if (!held_off && beats_taken >= 150) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 7) == 0) begin
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end
            if ($urandom_range(0, 199) == 0) begin
               steady = !steady;
            end
         end
      end
   end

   // Hang detection: any beat on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[ymodem_receiver] ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [7:0]  errs_by_phase [4];
      logic [15:0] ms_by_phase [4];
      int          first_item;
      // Low extremes, high extremes (no timeouts and no retry cancels), then two ordinary
      // settings.
      errs_by_phase = '{8'd1, 8'd255, 8'd3, 8'd2};
      ms_by_phase = '{16'd1, 16'd65535, 16'd7, 16'd20};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset register values.
      // A frame end with no bytes and an unused command both produce nothing.
      send_item(CMD_FRAME_END, 8'h00);
      send_item(CMD_UNUSED, 8'hFF);
      // Garbage header: 'C' and one retry counted.
      send_item(CMD_BYTE, 8'hFF);
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_FRAME_END, 8'hFF);
      // EOT is refused once, then confirmed with ACK and 'C'.
      send_item(CMD_BYTE, B_EOT);
      send_item(CMD_FRAME_END, 8'h00);
      send_item(CMD_BYTE, B_EOT);
      send_item(CMD_FRAME_END, 8'h00);
      // Both forms of abort cancel the transfer.
      send_item(CMD_BYTE, B_ETX);
      send_item(CMD_FRAME_END, 8'h00);
      send_item(CMD_BYTE, B_CA);
      send_item(CMD_BYTE, B_CA);
      send_item(CMD_FRAME_END, 8'h00);
      // A single CA is just a bad header.
      send_item(CMD_BYTE, B_CA);
      send_item(CMD_BYTE, 8'h55);
      send_item(CMD_FRAME_END, 8'h00);
      // Truncated 128- and 1024-byte blocks: payload passes through, then a reject event.
      send_item(CMD_BYTE, B_SOH);
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_BYTE, 8'hFF);
      send_item(CMD_BYTE, 8'h7E);
      send_item(CMD_FRAME_END, 8'h00);
      send_item(CMD_BYTE, B_STX);
      send_item(CMD_BYTE, 8'h01);
      send_item(CMD_BYTE, 8'hFE);
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_FRAME_END, 8'h00);
      send_item(CMD_TICK, 8'h00);

      // Tight limits: the header-phase timeout and the retry limit that forces a cancel.
      settle();
      configure(8'd1, 16'd2);
      send_item(CMD_TICK, 8'h00);
      send_item(CMD_TICK, 8'hFF);
      send_item(CMD_BYTE, 8'h7F);
      send_item(CMD_FRAME_END, 8'h00);
      send_item(CMD_BYTE, 8'h80);
      send_item(CMD_FRAME_END, 8'h00);

      // Random part, one stretch per register setting.
      for (int p = 0; p < 4; p++) begin
         settle();
         configure(errs_by_phase[p], ms_by_phase[p]);
         first_item = items_sent;
         while (items_sent - first_item < PHASE_ITEMS) begin
            run_scenario();
         end
      end

      settle();
      if (mismatches == 0 && replies_waiting == 0) begin
         $display("[ymodem_receiver] OK");
      end else begin
         $display("[ymodem_receiver] ERROR");
      end
      $finish;
   end

endmodule
